// ===== rtl/fcq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcq_pkg: shared types and codes for the circular FIFO queue unit
// Holds the input and result transaction structs and the command and status
// codes used by the control logic and the top level.
// ----------------------------------------------------------------------------
package fcq_pkg;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int WORD_W = 32;
  localparam int FILL_W = 8;

  typedef struct packed {
    logic                     command;
    logic signed [WORD_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] head_word;
    logic signed [WORD_W-1:0] tail_word;
  } out_t;

endpackage

// ===== rtl/circular_fifo_queue_unit.sv =====
`timescale 1ns / 1ps
// A transaction's result passes the fcq_ctrl states S_RD and S_HOLD and the
// output register before out_valid; no new transaction is accepted until the
// result leaves S_HOLD, after the head fetch through the registered read port.
// Reset (rst_n, synchronous, active low) empties the queue: pointers and count
// go to zero; the word store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// circular_fifo_queue_unit: ring-buffer FIFO of signed 32-bit words
// Takes enqueue or dequeue transactions and returns one result each with the
// status, the fill count, an empty flag and the head and tail words.
// ----------------------------------------------------------------------------
module circular_fifo_queue_unit #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fcq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fcq_pkg::out_t out_data
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  logic                              res_valid;
  logic                              res_take;
  fcq_pkg::out_t                     res_data;
  logic                              mem_wr_en;
  logic [ADDR_W-1:0]                 mem_wr_addr;
  logic signed [fcq_pkg::WORD_W-1:0] mem_wr_data;
  logic                              mem_rd_en;
  logic [ADDR_W-1:0]                 mem_rd_addr;
  logic signed [fcq_pkg::WORD_W-1:0] mem_rd_data;

  logic          out_valid_r, out_valid_nxt;
  fcq_pkg::out_t out_data_r;

  fcq_ctrl #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fcq_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/fcq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcq_mem: word store of the queue
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module fcq_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic signed [fcq_pkg::WORD_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [ADDR_W-1:0]                rd_addr,
  output logic signed [fcq_pkg::WORD_W-1:0] rd_data
);

  logic signed [fcq_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fcq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcq_ctrl: pointer, count and sequencing logic of the queue
// Applies one transaction at a time: updates pointers and count, writes the
// store on enqueue, fetches the new head on dequeue and builds the result.
// ----------------------------------------------------------------------------
module fcq_ctrl #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transaction
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fcq_pkg::in_t                      in_data,
  // result toward the output register
  output logic                              res_valid,
  input  logic                              res_take,
  output fcq_pkg::out_t                     res_data,
  // word store
  output logic                              mem_wr_en,
  output logic [ADDR_W-1:0]                 mem_wr_addr,
  output logic signed [fcq_pkg::WORD_W-1:0] mem_wr_data,
  output logic                              mem_rd_en,
  output logic [ADDR_W-1:0]                 mem_rd_addr,
  input  logic signed [fcq_pkg::WORD_W-1:0] mem_rd_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(DEPTH - 1);

  logic [1:0]                        state_r, state_nxt;
  logic [ADDR_W-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [1:0]                        status_r, status_nxt;
  logic                              head_load_r, head_load_nxt;
  logic signed [fcq_pkg::WORD_W-1:0] head_r, head_nxt;
  logic signed [fcq_pkg::WORD_W-1:0] tail_r, tail_nxt;

  logic              accept;
  logic              enq_ok;
  logic              deq_ok;
  logic [ADDR_W-1:0] rd_ptr_inc;
  logic [ADDR_W-1:0] wr_ptr_inc;
  logic [CNT_W+fcq_pkg::FILL_W-1:0] count_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Classify the transaction against the current fill
  assign enq_ok = accept && (in_data.command == fcq_pkg::CMD_ENQ) && (count_r != CNT_FULL);
  assign deq_ok = accept && (in_data.command == fcq_pkg::CMD_DEQ) && (count_r != '0);

  // Wrap pointers at the last slot
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;

  // Store access: write on enqueue, fetch the next head on dequeue
  assign mem_wr_en   = enq_ok;
  assign mem_wr_addr = wr_ptr_r;
  assign mem_wr_data = in_data.data_in;
  assign mem_rd_en   = deq_ok && (count_r > CNT_W'(1));
  assign mem_rd_addr = rd_ptr_inc;

  // Next state of pointers, count, status and cached end words
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    head_load_nxt = head_load_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt     = S_RD;
          head_load_nxt = mem_rd_en;
          status_nxt    = fcq_pkg::ST_DONE;
          if (in_data.command == fcq_pkg::CMD_ENQ) begin
            if (enq_ok) begin
              wr_ptr_nxt = wr_ptr_inc;
              count_nxt  = count_r + 1'b1;
              tail_nxt   = in_data.data_in;
              if (count_r == '0) begin
                head_nxt = in_data.data_in;
              end
            end else begin
              status_nxt = fcq_pkg::ST_OVERFLOW;
            end
          end else begin
            if (deq_ok) begin
              rd_ptr_nxt = rd_ptr_inc;
              count_nxt  = count_r - 1'b1;
            end else begin
              status_nxt = fcq_pkg::ST_UNDERFLOW;
            end
          end
        end
      end
      S_RD: begin
        // take the fetched head word
        if (head_load_r) begin
          head_nxt = mem_rd_data;
        end
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    head_load_r <= head_load_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
  end

  // Build the result; end words read as zero when empty
  assign count_ext = {{fcq_pkg::FILL_W{1'b0}}, count_r};
  assign res_valid = (state_r == S_HOLD);

  always_comb begin
    res_data.status     = status_r;
    res_data.fill_count = count_ext[fcq_pkg::FILL_W-1:0];
    res_data.is_empty   = (count_r == '0);
    res_data.head_word  = (count_r == '0) ? '0 : head_r;
    res_data.tail_word  = (count_r == '0) ? '0 : tail_r;
  end

  // Count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("fcq_ctrl: count above depth");

  // Empty or full queue has coinciding pointers
  a_ptr_align: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> (rd_ptr_r == wr_ptr_r))
    else $error("fcq_ctrl: pointers out of step with count");

  // An accepted transaction moves the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1
                || count_r == $past(count_r) - 1'b1))
    else $error("fcq_ctrl: count jumped");

  // Without a transaction, count and pointers hold
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept && $past(rst_n)) |=> ($stable(count_r) && $stable(rd_ptr_r)
                                   && $stable(wr_ptr_r)))
    else $error("fcq_ctrl: state changed without a transaction");

endmodule
